>>> rtl/piecewise_linear_sensor_map_macros.svh
// Assertion macros used by the RTL.
`ifndef PIECEWISE_LINEAR_SENSOR_MAP_MACROS_SVH
`define PIECEWISE_LINEAR_SENSOR_MAP_MACROS_SVH

`ifndef SYNTHESIS

`define PLSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("implication property violated");

`define PLSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("next-cycle property violated");

`else

`define PLSM_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define PLSM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/plsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plsm_pkg;

   localparam int SampleWidth   = 12;
   localparam int ValueWidth    = 16;
   localparam int BpPairWidth   = 2 * SampleWidth;
   localparam int ValPairWidth  = 2 * ValueWidth;
   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth  = 32;
   localparam int NumPoints     = 8;
   localparam int NumPairs      = NumPoints / 2;
   localparam int LastSegment   = 7;

   localparam int DivisorWidth  = SampleWidth;
   localparam int QuotWidth     = 28;
   localparam int BitsPerStage  = 2;
   localparam int DivStages     = QuotWidth / BitsPerStage;
   localparam int RspLatency    = 4 + DivStages;

   typedef logic [SampleWidth-1:0]          sample_type;
   typedef logic signed [ValueWidth-1:0]    value_type;
   typedef logic [2:0]                      seg_type;
   typedef logic [CsrIndexWidth-1:0]        csr_index_type;

   localparam csr_index_type RegBpPair0  = 4'd0;
   localparam csr_index_type RegBpPair1  = 4'd1;
   localparam csr_index_type RegBpPair2  = 4'd2;
   localparam csr_index_type RegBpPair3  = 4'd3;
   localparam csr_index_type RegValPair0 = 4'd4;
   localparam csr_index_type RegValPair1 = 4'd5;
   localparam csr_index_type RegValPair2 = 4'd6;
   localparam csr_index_type RegValPair3 = 4'd7;

   localparam logic [BpPairWidth-1:0]  BpPair0Reset  = 24'd2097152;
   localparam logic [BpPairWidth-1:0]  BpPair1Reset  = 24'd6292480;
   localparam logic [BpPairWidth-1:0]  BpPair2Reset  = 24'd10487808;
   localparam logic [BpPairWidth-1:0]  BpPair3Reset  = 24'd16776192;
   localparam logic [ValPairWidth-1:0] ValPair0Reset = 32'd1376256;
   localparam logic [ValPairWidth-1:0] ValPair1Reset = 32'd4194347;
   localparam logic [ValPairWidth-1:0] ValPair2Reset = 32'd7012438;
   localparam logic [ValPairWidth-1:0] ValPair3Reset = 32'd9830529;

   typedef struct packed {
      value_type base;
      logic      negate;
      logic      bypass;
      logic      zero_width;
   } side_type;

endpackage

`default_nettype wire

>>> rtl/plsm_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module plsm_divider import plsm_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic [QuotWidth-1:0]    in_dividend,
   input  wire logic [DivisorWidth-1:0] in_divisor,
   input  wire side_type                in_side,
   output logic                         out_valid,
   output logic [QuotWidth-1:0]         out_quotient,
   output side_type                     out_side
);

   localparam int AccWidth = DivisorWidth + QuotWidth;

   logic [DivStages-1:0]    valid_src;
   logic [QuotWidth-1:0]    word_src    [DivStages];
   logic [DivisorWidth-1:0] rem_src     [DivStages];
   logic [DivisorWidth-1:0] divisor_src [DivStages];
   side_type                side_src    [DivStages];

   logic [DivStages-1:0]    valid_ff;
   logic [QuotWidth-1:0]    word_ff     [DivStages];
   logic [QuotWidth-1:0]    word_in     [DivStages];
   logic [DivisorWidth-1:0] rem_ff      [DivStages];
   logic [DivisorWidth-1:0] rem_in      [DivStages];
   logic [DivisorWidth-1:0] divisor_ff  [DivStages];
   side_type                side_ff     [DivStages];

   function automatic logic [AccWidth-1:0] div_step(
      input logic [DivisorWidth-1:0] rem,
      input logic [QuotWidth-1:0]    word,
      input logic [DivisorWidth-1:0] divisor
   );
      logic [DivisorWidth:0] trial;
      logic [DivisorWidth:0] diff;
      trial = {rem, word[QuotWidth-1]};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         return {diff[DivisorWidth-1:0], word[QuotWidth-2:0], 1'b1};
      end else begin
         return {trial[DivisorWidth-1:0], word[QuotWidth-2:0], 1'b0};
      end
   endfunction

   genvar s;
   generate
      for (s = 0; s < DivStages; s++) begin : g_stage
         if (s == 0) begin : g_first
            assign valid_src[s]   = in_valid;
            assign word_src[s]    = in_dividend;
            assign rem_src[s]     = '0;
            assign divisor_src[s] = in_divisor;
            assign side_src[s]    = in_side;
         end else begin : g_next
            assign valid_src[s]   = valid_ff[s-1];
            assign word_src[s]    = word_ff[s-1];
            assign rem_src[s]     = rem_ff[s-1];
            assign divisor_src[s] = divisor_ff[s-1];
            assign side_src[s]    = side_ff[s-1];
         end
      end
   endgenerate

   always_comb begin
      logic [AccWidth-1:0] acc;
      for (int k = 0; k < DivStages; k++) begin
         acc = {rem_src[k], word_src[k]};
         for (int j = 0; j < BitsPerStage; j++) begin
            acc = div_step(acc[AccWidth-1:QuotWidth], acc[QuotWidth-1:0], divisor_src[k]);
         end
         rem_in[k]  = acc[AccWidth-1:QuotWidth];
         word_in[k] = acc[QuotWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_src;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DivStages; k++) begin
         word_ff[k]    <= word_in[k];
         rem_ff[k]     <= rem_in[k];
         divisor_ff[k] <= divisor_src[k];
         side_ff[k]    <= side_src[k];
      end
   end

   assign out_valid    = valid_ff[DivStages-1];
   assign out_quotient = word_ff[DivStages-1];
   assign out_side     = side_ff[DivStages-1];

endmodule

`default_nettype wire

>>> rtl/piecewise_linear_sensor_map.sv
`timescale 1ns / 1ps
`default_nettype none
`include "piecewise_linear_sensor_map_macros.svh"

// Maps a 12-bit converter sample through an 8-point piecewise-linear curve held in
// eight configuration registers. A sample transfers at every clock edge with start high
// and busy low; busy is a registered copy of reset, so it falls after reset is released,
// then stays low, and one sample per clock is taken. Each sample gives exactly one result on
// rsp_mapped_value and rsp_zero_width_segment, shown for one cycle with rsp_strobe high.
// The result passes through the segment search, the operand selection, the multiplier,
// the sign stage, the 14-stage divider (two quotient bits a stage) and the output
// register. The receiver cannot stall; results are in transfer order. Write the
// configuration registers only while no sample is in flight.
module piecewise_linear_sensor_map import plsm_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [SampleWidth-1:0]   req_adc_sample,
   output logic                          busy,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata,
   output logic                          rsp_strobe,
   output logic signed [ValueWidth-1:0]  rsp_mapped_value,
   output logic                          rsp_zero_width_segment
);

   logic                     busy_ff;
   logic [BpPairWidth-1:0]   bp_pair_ff  [NumPairs];
   logic [ValPairWidth-1:0]  val_pair_ff [NumPairs];
   sample_type               bp  [NumPoints];
   value_type                val [NumPoints];

   logic                     accept;
   seg_type                  s1_seg_in;
   logic                     s1_valid_ff;
   sample_type               s1_sample_ff;
   seg_type                  s1_seg_ff;

   sample_type               bp_lo;
   sample_type               bp_hi;
   value_type                val_lo;
   value_type                val_hi;
   logic signed [ValueWidth:0]  s2_rise_in;
   logic signed [SampleWidth:0] s2_run_in;
   logic signed [SampleWidth:0] s2_width_in;
   logic                     s2_valid_ff;
   logic signed [ValueWidth:0]  s2_rise_ff;
   logic signed [SampleWidth:0] s2_run_ff;
   logic signed [SampleWidth:0] s2_width_ff;
   side_type                 s2_side_in;
   side_type                 s2_side_ff;

   logic                     s3_valid_ff;
   logic signed [QuotWidth+1:0] s3_prod_ff;
   logic signed [SampleWidth:0] s3_width_ff;
   side_type                 s3_side_ff;

   logic [QuotWidth+1:0]     prod_mag;
   logic [SampleWidth:0]     width_mag;
   logic                     s4_valid_ff;
   logic [QuotWidth-1:0]     s4_dividend_ff;
   logic [DivisorWidth-1:0]  s4_divisor_ff;
   side_type                 s4_side_in;
   side_type                 s4_side_ff;

   logic                     div_valid;
   logic [QuotWidth-1:0]     div_quotient;
   side_type                 div_side;

   logic [ValueWidth-1:0]    quot_adj;
   logic [ValueWidth-1:0]    result_in;
   logic                     rsp_strobe_ff;
   logic [ValueWidth-1:0]    rsp_value_ff;
   logic                     rsp_zero_ff;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bp_pair_ff[0]  <= BpPair0Reset;
         bp_pair_ff[1]  <= BpPair1Reset;
         bp_pair_ff[2]  <= BpPair2Reset;
         bp_pair_ff[3]  <= BpPair3Reset;
         val_pair_ff[0] <= ValPair0Reset;
         val_pair_ff[1] <= ValPair1Reset;
         val_pair_ff[2] <= ValPair2Reset;
         val_pair_ff[3] <= ValPair3Reset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegBpPair0:  bp_pair_ff[0]  <= csr_wdata[BpPairWidth-1:0];
            RegBpPair1:  bp_pair_ff[1]  <= csr_wdata[BpPairWidth-1:0];
            RegBpPair2:  bp_pair_ff[2]  <= csr_wdata[BpPairWidth-1:0];
            RegBpPair3:  bp_pair_ff[3]  <= csr_wdata[BpPairWidth-1:0];
            RegValPair0: val_pair_ff[0] <= csr_wdata[ValPairWidth-1:0];
            RegValPair1: val_pair_ff[1] <= csr_wdata[ValPairWidth-1:0];
            RegValPair2: val_pair_ff[2] <= csr_wdata[ValPairWidth-1:0];
            RegValPair3: val_pair_ff[3] <= csr_wdata[ValPairWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int m = 0; m < NumPairs; m++) begin
         bp[2*m]    = bp_pair_ff[m][SampleWidth-1:0];
         bp[2*m+1]  = bp_pair_ff[m][BpPairWidth-1:SampleWidth];
         val[2*m]   = val_pair_ff[m][ValueWidth-1:0];
         val[2*m+1] = val_pair_ff[m][ValPairWidth-1:ValueWidth];
      end
   end

   // stage 1: segment search
   always_comb begin
      s1_seg_in = seg_type'(LastSegment);
      for (int k = LastSegment - 1; k >= 0; k--) begin
         if (req_adc_sample < bp[k+1]) begin
            s1_seg_in = seg_type'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_sample_ff <= req_adc_sample;
      s1_seg_ff    <= s1_seg_in;
   end

   // stage 2: segment operands
   always_comb begin
      bp_lo  = bp[0];
      bp_hi  = bp[1];
      val_lo = val[0];
      val_hi = val[1];
      for (int k = 1; k < LastSegment; k++) begin
         if (s1_seg_ff == seg_type'(k)) begin
            bp_lo  = bp[k];
            bp_hi  = bp[k+1];
            val_lo = val[k];
            val_hi = val[k+1];
         end
      end
      if (s1_seg_ff == seg_type'(LastSegment)) begin
         val_lo = val[LastSegment];
      end
      s2_rise_in  = {val_hi[ValueWidth-1], val_hi} - {val_lo[ValueWidth-1], val_lo};
      s2_run_in   = {1'b0, s1_sample_ff} - {1'b0, bp_lo};
      s2_width_in = {1'b0, bp_hi} - {1'b0, bp_lo};
      s2_side_in.base       = val_lo;
      s2_side_in.negate     = 1'b0;
      s2_side_in.zero_width = (s1_seg_ff != seg_type'(LastSegment)) && (s2_width_in == '0);
      s2_side_in.bypass     = (s1_seg_ff == seg_type'(LastSegment)) || (s2_width_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_rise_ff  <= s2_rise_in;
      s2_run_ff   <= s2_run_in;
      s2_width_ff <= s2_width_in;
      s2_side_ff  <= s2_side_in;
   end

   // stage 3: multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_prod_ff  <= s2_rise_ff * s2_run_ff;
      s3_width_ff <= s2_width_ff;
      s3_side_ff  <= s2_side_ff;
   end

   // stage 4: magnitudes and quotient sign
   always_comb begin
      prod_mag  = s3_prod_ff[QuotWidth+1] ? -s3_prod_ff : s3_prod_ff;
      width_mag = s3_width_ff[SampleWidth] ? -s3_width_ff : s3_width_ff;
      s4_side_in        = s3_side_ff;
      s4_side_in.negate = s3_prod_ff[QuotWidth+1] ^ s3_width_ff[SampleWidth];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_dividend_ff <= prod_mag[QuotWidth-1:0];
      s4_divisor_ff  <= width_mag[DivisorWidth-1:0];
      s4_side_ff     <= s4_side_in;
   end

   plsm_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s4_valid_ff),
      .in_dividend  (s4_dividend_ff),
      .in_divisor   (s4_divisor_ff),
      .in_side      (s4_side_ff),
      .out_valid    (div_valid),
      .out_quotient (div_quotient),
      .out_side     (div_side)
   );

   // output stage: apply sign and add base (or pass base alone on bypass), wrap
   always_comb begin
      quot_adj = div_side.negate ? (~div_quotient[ValueWidth-1:0] + 16'd1)
                                 : div_quotient[ValueWidth-1:0];
      if (div_side.bypass) begin
         result_in = div_side.base;
      end else begin
         result_in = div_side.base + quot_adj;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_valid;
      end
      rsp_value_ff <= result_in;
      rsp_zero_ff  <= div_side.zero_width;
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_mapped_value       = rsp_value_ff;
   assign rsp_zero_width_segment = rsp_zero_ff;

   `PLSM_ASSERT_IMPLY(a_rsp_latency, clock, reset, accept, ##(RspLatency + 1) rsp_strobe)
   `PLSM_ASSERT_IMPLY(a_zero_bypass, clock, reset, div_valid && div_side.zero_width, div_side.bypass)
   `PLSM_ASSERT_NEXT(a_not_busy, clock, reset, 1'b1, !busy)

endmodule

`default_nettype wire

>>> bench/tb_piecewise_linear_sensor_map.sv
`timescale 1ns / 1ps

module tb_piecewise_linear_sensor_map;
   import plsm_pkg::*;

   localparam int CycleLimit    = 400000;
   localparam int PhaseItems    = 175;
   localparam int NumPhases     = 8;

   logic                     clock;
   logic                     reset;
   logic                     start;
   sample_type               req_adc_sample;
   logic                     busy;
   logic                     csr_valid;
   logic                     csr_ready;
   csr_index_type            csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;
   logic                     rsp_strobe;
   value_type                rsp_mapped_value;
   logic                     rsp_zero_width_segment;

   piecewise_linear_sensor_map i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .req_adc_sample         (req_adc_sample),
      .busy                   (busy),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .rsp_strobe             (rsp_strobe),
      .rsp_mapped_value       (rsp_mapped_value),
      .rsp_zero_width_segment (rsp_zero_width_segment)
   );

   class curve_scoreboard;
      sample_type knot [NumPoints];
      value_type  level [NumPoints];
      value_type  want_value [$];
      logic       want_flag [$];
      int         errors;

      function new();
         errors = 0;
         load_reg(RegBpPair0, 32'(BpPair0Reset));
         load_reg(RegBpPair1, 32'(BpPair1Reset));
         load_reg(RegBpPair2, 32'(BpPair2Reset));
         load_reg(RegBpPair3, 32'(BpPair3Reset));
         load_reg(RegValPair0, 32'(ValPair0Reset));
         load_reg(RegValPair1, 32'(ValPair1Reset));
         load_reg(RegValPair2, 32'(ValPair2Reset));
         load_reg(RegValPair3, 32'(ValPair3Reset));
      endfunction

      function void load_reg(csr_index_type idx, logic [CsrDataWidth-1:0] data);
         int k;
         k = int'(idx);
         if (k < NumPairs) begin
            knot[2*k]   = data[SampleWidth-1:0];
            knot[2*k+1] = data[BpPairWidth-1:SampleWidth];
         end else if (k < NumPoints) begin
            level[2*(k-NumPairs)]   = data[ValueWidth-1:0];
            level[2*(k-NumPairs)+1] = data[ValPairWidth-1:ValueWidth];
         end
      endfunction

      function void note_sample(sample_type s);
         int        seg;
         longint    span;
         longint    rise;
         longint    run;
         longint    sum;
         value_type y;
         logic      flag;
         seg = 0;
         while (seg < LastSegment && s >= knot[seg+1])
            seg++;
         y = level[seg];
         flag = 1'b0;
         if (seg < LastSegment) begin
            span = longint'(knot[seg+1]) - longint'(knot[seg]);
            if (span == 0) begin
               flag = 1'b1;
            end else begin
               rise = longint'(level[seg+1]) - longint'(level[seg]);
               run  = longint'(s) - longint'(knot[seg]);
               sum  = longint'(level[seg]) + (rise * run) / span;
               y    = sum[ValueWidth-1:0];
            end
         end
         want_value.push_back(y);
         want_flag.push_back(flag);
      endfunction

      function int pending();
         return want_value.size();
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(value_type got_value, logic got_flag);
         value_type exp_value;
         logic      exp_flag;
         if (want_value.size() == 0) begin
            report($sformatf("unexpected result %0d flag %b", got_value, got_flag));
         end else begin
            exp_value = want_value.pop_front();
            exp_flag  = want_flag.pop_front();
            if (got_value !== exp_value)
               report($sformatf("mapped_value %0d, want %0d", got_value, exp_value));
            if (got_flag !== exp_flag)
               report($sformatf("zero_width_segment %b, want %b", got_flag, exp_flag));
         end
      endtask

      task close();
         if (want_value.size() != 0)
            report($sformatf("%0d results never arrived", want_value.size()));
      endtask
   endclass

   curve_scoreboard sb;
   int              cycle_count;
   sample_type      cur_bp [NumPoints];
   value_type       cur_val [NumPoints];
   logic [CsrDataWidth-1:0] reg_image [NumPoints];

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_piecewise_linear_sensor_map: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_sample(req_adc_sample);
         if (rsp_strobe)
            sb.check_result(rsp_mapped_value, rsp_zero_width_segment);
      end
   end

   task send_sample(input sample_type s, input int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         req_adc_sample = sample_type'($urandom_range(4095));
         @(negedge clock);
      end
      start = 1'b1;
      req_adc_sample = s;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task drain_results();
      start = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (RspLatency + 4) @(negedge clock);
   endtask

   task write_reg(input csr_index_type idx, input logic [CsrDataWidth-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      sb.load_reg(idx, data);
      @(negedge clock);
   endtask

   task commit_regs();
      int r;
      int j;
      r = $urandom_range(NumPoints - 1);
      for (j = 0; j < NumPoints; j++)
         write_reg(csr_index_type'((r + j) % NumPoints), reg_image[(r + j) % NumPoints]);
      write_reg(csr_index_type'(NumPoints + $urandom_range(NumPoints - 1)), $urandom());
      csr_valid = 1'b0;
   endtask

   task pack_curve();
      int k;
      for (k = 0; k < NumPairs; k++) begin
         reg_image[k] = {8'($urandom_range(255)), cur_bp[2*k+1], cur_bp[2*k]};
         reg_image[NumPairs+k] = {cur_val[2*k+1], cur_val[2*k]};
      end
      commit_regs();
   endtask

   task random_curve();
      int         j;
      int         k;
      int         span;
      sample_type t;
      for (k = 0; k < NumPoints; k++)
         cur_bp[k] = sample_type'($urandom_range(4095));
      for (j = 0; j < NumPoints; j++)
         for (k = 0; k < NumPoints - 1; k++)
            if (cur_bp[k] > cur_bp[k+1]) begin
               t = cur_bp[k];
               cur_bp[k] = cur_bp[k+1];
               cur_bp[k+1] = t;
            end
      if ($urandom_range(3) == 0)
         cur_bp[1] = cur_bp[0];
      if ($urandom_range(3) == 0)
         cur_bp[0] = sample_type'($urandom_range(4095));
      span = $urandom_range(1) ? 65535 : 2000;
      for (k = 0; k < NumPoints; k++)
         cur_val[k] = value_type'($urandom_range(span) - span / 2);
      pack_curve();
   endtask

   function sample_type pick_sample();
      int r;
      r = $urandom_range(7);
      if (r < 4)
         return sample_type'($urandom_range(4095));
      else if (r < 7)
         return sample_type'(sb.knot[$urandom_range(NumPoints - 1)]
                             + sample_type'($urandom_range(4)) - 12'd2);
      else
         return $urandom_range(1) ? '1 : '0;
   endfunction

   initial begin
      int p;
      int n;
      int k;
      int phase_gap;
      sb = new();
      cycle_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_adc_sample = '0;
      csr_valid = 1'b0;
      csr_index = RegBpPair0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_sample(12'd0, 0);
      send_sample(12'd1, 0);
      send_sample(12'd512, 0);
      send_sample(12'd2047, 0);
      send_sample(12'd3072, 0);
      send_sample(12'd4094, 0);
      send_sample(12'd4095, 0);
      send_sample(12'hAAA, 0);
      send_sample(12'h555, 0);
      drain_results();

      cur_bp  = '{12'd100, 12'd100, 12'd600, 12'd1200, 12'd1800, 12'd2400, 12'd3000, 12'd3600};
      cur_val = '{-16'sd1000, 16'sd500, 16'sd2000, -16'sd3000,
                  16'h7FFF, 16'h8000, 16'sd7, 16'sd0};
      pack_curve();
      send_sample(12'd0, 0);
      send_sample(12'd99, 0);
      send_sample(12'd100, 0);
      send_sample(12'd4095, 0);
      drain_results();

      cur_bp  = '{12'd0, 12'd585, 12'd1170, 12'd1755, 12'd2340, 12'd2925, 12'd3510, 12'd4095};
      cur_val = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                  16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
      pack_curve();
      send_sample(12'd0, 0);
      send_sample(12'd584, 0);
      send_sample(12'd585, 0);
      send_sample(12'd2000, 0);
      send_sample(12'd4094, 0);
      send_sample(12'd4095, 0);
      drain_results();

      cur_bp  = '{12'd4095, 12'd10, 12'd20, 12'd30, 12'd40, 12'd50, 12'd60, 12'd70};
      cur_val = '{16'h7FFF, 16'h8000, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6};
      pack_curve();
      send_sample(12'd0, 0);
      send_sample(12'd9, 0);
      send_sample(12'd10, 0);
      send_sample(12'd4095, 0);
      drain_results();

      for (p = 0; p < NumPhases; p++) begin
         if (p == 0) begin
            for (k = 0; k < NumPoints; k++)
               reg_image[k] = '1;
            commit_regs();
         end else if (p == 1) begin
            for (k = 0; k < NumPoints; k++)
               reg_image[k] = '0;
            commit_regs();
         end else if (p == 2) begin
            reg_image[RegBpPair0]  = 32'(BpPair0Reset);
            reg_image[RegBpPair1]  = 32'(BpPair1Reset);
            reg_image[RegBpPair2]  = 32'(BpPair2Reset);
            reg_image[RegBpPair3]  = 32'(BpPair3Reset);
            reg_image[RegValPair0] = ValPair0Reset;
            reg_image[RegValPair1] = ValPair1Reset;
            reg_image[RegValPair2] = ValPair2Reset;
            reg_image[RegValPair3] = ValPair3Reset;
            commit_regs();
         end else if (p % 2 == 1) begin
            for (k = 0; k < NumPoints; k++)
               reg_image[k] = $urandom();
            commit_regs();
         end else begin
            random_curve();
         end
         phase_gap = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 46 : 23);
         for (n = 0; n < PhaseItems; n++) begin
            if (n == 90)
               drain_results();
            send_sample(pick_sample(), (n % 64 < 16) ? 0 : phase_gap);
         end
         drain_results();
      end

      sb.close();
      if (sb.errors == 0)
         $display("tb_piecewise_linear_sensor_map: clean");
      else
         $display("tb_piecewise_linear_sensor_map: errors");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/plsm_pkg.sv
rtl/plsm_divider.sv
rtl/piecewise_linear_sensor_map.sv
bench/tb_piecewise_linear_sensor_map.sv
